// ===== design/wtrh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtrh_pkg
// Shared sizes, register codes and helpers of the write trace region histogram.
// ----------------------------------------------------------------------------
package wtrh_pkg;

  // Geometry; page size and pages per bin are powers of two
  localparam int NUM_BINS      = 128;
  localparam int PAGES_PER_BIN = 4096;
  localparam int PAGE_BYTES    = 4096;

  // Field widths
  localparam int ADDR_W = 48;
  localparam int SIZE_W = 21;
  localparam int SEL_W  = 7;
  localparam int JPG_W  = 20;
  localparam int CNT32  = 32;
  localparam int CNT48  = 48;

  // Derived widths
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int BIN_SHIFT  = $clog2(PAGES_PER_BIN);
  localparam int BIN_W      = $clog2(NUM_BINS);
  localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
  localparam int CUR_W      = PAGE_W + 1;           // page plus run offset
  localparam int SUM_W      = SIZE_W + 1;
  localparam int CNT_W      = SUM_W - PAGE_SHIFT;   // pages covered by one write
  localparam longint PAGE_LIMIT = longint'(NUM_BINS) * longint'(PAGES_PER_BIN);

  // Stream payload widths
  localparam int IN_W  = ((ADDR_W + SIZE_W + SEL_W + 7) / 8) * 8;
  localparam int OUT_W = 2 * CNT32 + 3 * CNT48 + CNT32;
  localparam int RAM_W = 2 * CNT32;                 // {data bin, all bin}

  // Reset values of the configuration registers
  localparam logic [ADDR_W-1:0] BASE_RST   = 48'h0001_0000_0000;
  localparam logic [JPG_W-1:0]  JFIRST_RST = 20'd48;
  localparam logic [JPG_W-1:0]  JLAST_RST  = 20'd63;
  localparam logic [SIZE_W-1:0] INODE_RST  = 21'd128;

  // Configuration register index
  typedef enum logic [1:0] {
    CFG_BASE_OFFSET   = 2'd0,
    CFG_JOURNAL_FIRST = 2'd1,
    CFG_JOURNAL_LAST  = 2'd2,
    CFG_INODE_SIZE    = 2'd3
  } cfg_idx_e;

  // Beat kind carried in tuser
  typedef enum logic {
    MODE_RECORD = 1'b0,
    MODE_READ   = 1'b1
  } mode_e;

  // Saturating increments
  function automatic logic [CNT32-1:0] sat_inc32(input logic [CNT32-1:0] v);
    sat_inc32 = (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [CNT48-1:0] sat_inc48(input logic [CNT48-1:0] v);
    sat_inc48 = (&v) ? v : v + 1'b1;
  endfunction

endpackage

// ===== design/wtrh_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtrh_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module wtrh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/write_trace_region_histogram_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// write_trace_region_histogram_unit
// Page-region histogram of a storage write trace, with totals and read-back.
// ----------------------------------------------------------------------------
// Beats on the input stream are either write records (tuser = 0) or bin reads
// (tuser = 1); a read returns one result beat, a record returns none. Items are
// handled one at a time. A read is accepted in idle, issues its bin read, then
// loads the result register once the output register is free. A record has its
// page taken from the address when accepted and is then classified; after that
// each covered page whose bin is inside the table takes a bin read and a write-back,
// and each page beyond it is counted without a RAM access. The two steps per
// in-table page are set by the read-modify-write of the single histogram RAM,
// which holds both bin counts of a bin in one word. The histograms read as zero
// after reset through per-bin valid flags, so there is no clearing pass. The
// input is taken again as soon as a result is in the output register.
// ----------------------------------------------------------------------------
module write_trace_region_histogram_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [wtrh_pkg::ADDR_W-1:0]    cfg_data_i,
  // Input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: write_address[47:0], write_size[68:48], bin_select[75:69], zero fill
  input  logic [wtrh_pkg::IN_W-1:0]      s_axis_tdata,
  // tuser: mode
  input  logic [0:0]                     s_axis_tuser,
  // Result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: all_bin_count[31:0], data_bin_count[63:32], journal_writes[111:64],
  //        inode_writes[159:112], data_page_writes[207:160],
  //        out_of_range_writes[239:208]
  output logic [wtrh_pkg::OUT_W-1:0]     m_axis_tdata
);

  localparam int ADDR_W = wtrh_pkg::ADDR_W;
  localparam int SIZE_W = wtrh_pkg::SIZE_W;
  localparam int SEL_W  = wtrh_pkg::SEL_W;
  localparam int JPG_W  = wtrh_pkg::JPG_W;
  localparam int PAGE_W = wtrh_pkg::PAGE_W;
  localparam int CUR_W  = wtrh_pkg::CUR_W;
  localparam int CNT_W  = wtrh_pkg::CNT_W;
  localparam int SUM_W  = wtrh_pkg::SUM_W;
  localparam int BIN_W  = wtrh_pkg::BIN_W;
  localparam int C32    = wtrh_pkg::CNT32;
  localparam int C48    = wtrh_pkg::CNT48;
  localparam int NBINS  = wtrh_pkg::NUM_BINS;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_CLASS    = 6'b000010,
    S_ISSUE    = 6'b000100,
    S_UPDATE   = 6'b001000,
    S_RD_ISSUE = 6'b010000,
    S_RD_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [ADDR_W-1:0] base_q, base_d;
  logic [JPG_W-1:0]  jfirst_q, jfirst_d;
  logic [JPG_W-1:0]  jlast_q, jlast_d;
  logic [SIZE_W-1:0] inode_q, inode_d;

  // Item registers
  logic [PAGE_W-1:0] page_q, page_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [SEL_W-1:0]  sel_q, sel_d;
  logic [CUR_W-1:0]  cur_q, cur_d;
  logic [CNT_W-1:0]  left_q, left_d;
  logic              is_data_q, is_data_d;

  // Totals and valid flags
  logic [C48-1:0]    jtot_q, jtot_d;
  logic [C48-1:0]    itot_q, itot_d;
  logic [C48-1:0]    dtot_q, dtot_d;
  logic [C32-1:0]    ovf_q, ovf_d;
  logic [NBINS-1:0]  valid_q, valid_d;
  logic              rvalid_q;

  // Output register
  logic [wtrh_pkg::OUT_W-1:0] out_q, out_d;
  logic                       m_valid_q, m_valid_d;

  // RAM port
  logic                       ram_we, ram_re;
  logic [BIN_W-1:0]           ram_addr;
  logic [wtrh_pkg::RAM_W-1:0] ram_wdata, ram_rdata;

  // Datapath helpers
  logic              in_fire, out_free;
  logic [ADDR_W-1:0] diff;
  logic [SUM_W-1:0]  size_sum;
  logic [CNT_W-1:0]  page_cnt;
  logic              in_jrnl, is_inode, in_range, sel_ok;
  logic [BIN_W-1:0]  cur_bin;
  logic [C32-1:0]    ent_all, ent_data;

  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign out_free = ~m_valid_q | m_axis_tready;

  // Page conversion and classification
  assign diff     = s_axis_tdata[ADDR_W-1:0] - base_q;
  assign size_sum = {1'b0, size_q} + SUM_W'(wtrh_pkg::PAGE_BYTES - 1);
  assign page_cnt = size_sum[SUM_W-1:wtrh_pkg::PAGE_SHIFT];
  assign in_jrnl  = (page_q >= PAGE_W'(jfirst_q)) && (page_q <= PAGE_W'(jlast_q));
  assign is_inode = (size_q == inode_q);

  // Current page to bin
  assign in_range = (cur_q < CUR_W'(wtrh_pkg::PAGE_LIMIT));
  assign cur_bin  = cur_q[wtrh_pkg::BIN_SHIFT +: BIN_W];
  assign sel_ok   = (int'(sel_q) < NBINS);

  // Bin word as read, zero where never written since reset
  assign ent_all  = rvalid_q ? ram_rdata[C32-1:0]   : '0;
  assign ent_data = rvalid_q ? ram_rdata[2*C32-1:C32] : '0;

  assign ram_wdata = {(is_data_q ? wtrh_pkg::sat_inc32(ent_data) : ent_data),
                      wtrh_pkg::sat_inc32(ent_all)};

  // Sequencer and next-state logic
  always_comb begin
    state_d   = state_q;
    base_d    = base_q;
    jfirst_d  = jfirst_q;
    jlast_d   = jlast_q;
    inode_d   = inode_q;
    page_d    = page_q;
    size_d    = size_q;
    sel_d     = sel_q;
    cur_d     = cur_q;
    left_d    = left_q;
    is_data_d = is_data_q;
    jtot_d    = jtot_q;
    itot_d    = itot_q;
    dtot_d    = dtot_q;
    ovf_d     = ovf_q;
    valid_d   = valid_q;
    out_d     = out_q;
    m_valid_d = m_valid_q & ~m_axis_tready;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = cur_bin;

    // Configuration writes
    if (cfg_we_i) begin
      unique case (wtrh_pkg::cfg_idx_e'(cfg_idx_i))
        wtrh_pkg::CFG_BASE_OFFSET:   base_d   = cfg_data_i;
        wtrh_pkg::CFG_JOURNAL_FIRST: jfirst_d = cfg_data_i[JPG_W-1:0];
        wtrh_pkg::CFG_JOURNAL_LAST:  jlast_d  = cfg_data_i[JPG_W-1:0];
        wtrh_pkg::CFG_INODE_SIZE:    inode_d  = cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          page_d = diff[ADDR_W-1:wtrh_pkg::PAGE_SHIFT];
          size_d = s_axis_tdata[ADDR_W +: SIZE_W];
          sel_d  = s_axis_tdata[ADDR_W+SIZE_W +: SEL_W];
          if (wtrh_pkg::mode_e'(s_axis_tuser[0]) == wtrh_pkg::MODE_READ) begin
            state_d = S_RD_ISSUE;
          end else begin
            state_d = S_CLASS;
          end
        end
      end

      // Journal, inode or a run of data pages
      S_CLASS: begin
        cur_d = {1'b0, page_q};
        priority if (in_jrnl) begin
          jtot_d    = wtrh_pkg::sat_inc48(jtot_q);
          left_d    = CNT_W'(1);
          is_data_d = 1'b0;
          state_d   = S_ISSUE;
        end else if (is_inode) begin
          itot_d    = wtrh_pkg::sat_inc48(itot_q);
          left_d    = CNT_W'(1);
          is_data_d = 1'b0;
          state_d   = S_ISSUE;
        end else begin
          left_d    = page_cnt;
          is_data_d = 1'b1;
          state_d   = (page_cnt == '0) ? S_IDLE : S_ISSUE;
        end
      end

      // Read the bin, or count a page beyond the table
      S_ISSUE: begin
        if (in_range) begin
          ram_re  = 1'b1;
          state_d = S_UPDATE;
        end else begin
          ovf_d = wtrh_pkg::sat_inc32(ovf_q);
          if (is_data_q) begin
            dtot_d = wtrh_pkg::sat_inc48(dtot_q);
          end
          cur_d   = cur_q + 1'b1;
          left_d  = left_q - 1'b1;
          state_d = (left_q == CNT_W'(1)) ? S_IDLE : S_ISSUE;
        end
      end

      // Write the bumped bin word back
      S_UPDATE: begin
        ram_we           = 1'b1;
        valid_d[cur_bin] = 1'b1;
        if (is_data_q) begin
          dtot_d = wtrh_pkg::sat_inc48(dtot_q);
        end
        cur_d   = cur_q + 1'b1;
        left_d  = left_q - 1'b1;
        state_d = (left_q == CNT_W'(1)) ? S_IDLE : S_ISSUE;
      end

      S_RD_ISSUE: begin
        ram_re   = 1'b1;
        ram_addr = BIN_W'(sel_q);
        state_d  = S_RD_OUT;
      end

      // Load the result register once it is free
      S_RD_OUT: begin
        if (out_free) begin
          out_d = {ovf_q, dtot_q, itot_q, jtot_q,
                   (sel_ok ? ent_data : {C32{1'b0}}),
                   (sel_ok ? ent_all : {C32{1'b0}})};
          m_valid_d = 1'b1;
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      base_q    <= wtrh_pkg::BASE_RST;
      jfirst_q  <= wtrh_pkg::JFIRST_RST;
      jlast_q   <= wtrh_pkg::JLAST_RST;
      inode_q   <= wtrh_pkg::INODE_RST;
      left_q    <= '0;
      jtot_q    <= '0;
      itot_q    <= '0;
      dtot_q    <= '0;
      ovf_q     <= '0;
      valid_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      base_q    <= base_d;
      jfirst_q  <= jfirst_d;
      jlast_q   <= jlast_d;
      inode_q   <= inode_d;
      left_q    <= left_d;
      jtot_q    <= jtot_d;
      itot_q    <= itot_d;
      dtot_q    <= dtot_d;
      ovf_q     <= ovf_d;
      valid_q   <= valid_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    page_q    <= page_d;
    size_q    <= size_d;
    sel_q     <= sel_d;
    cur_q     <= cur_d;
    is_data_q <= is_data_d;
    out_q     <= out_d;
    if (ram_re) begin
      rvalid_q <= valid_q[ram_addr];
    end
  end

  // Histogram store: {data bin, all bin} per bin
  wtrh_ram #(
    .WIDTH (wtrh_pkg::RAM_W),
    .DEPTH (NBINS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;

  // Checks
  a_we_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> in_range && (state_q == S_UPDATE))
    else $error("histogram write outside the table");

  a_run_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ISSUE || state_q == S_UPDATE) |-> (left_q != '0))
    else $error("page run active with no pages left");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD_OUT && out_free) |=> m_axis_tvalid)
    else $error("read finished without a result beat");

  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&ovf_q) |=> (&ovf_q))
    else $error("overflow counter wrapped");

  a_data_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&dtot_q) |=> (&dtot_q))
    else $error("data page total wrapped");

endmodule
